FILE: design/jfps_pkg.sv
// jfps_pkg: shared constants, register indexes and the queue entry type
// for the five-point stencil unit. No dependencies.
`timescale 1ns / 1ps

package jfps_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int SAMPLE_BITS = 32;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WID_W       = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W       = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(1024);
  localparam logic [ROW_W-1:0] HEIGHT_RST = ROW_W'(1024);

  // one interior point on its way to the back end: pairwise neighbour sums
  typedef struct packed {
    logic [SAMPLE_BITS:0] sum_tb;
    logic [SAMPLE_BITS:0] sum_lr;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
    logic                 last;
  } entry_t;

endpackage

FILE: design/jfps_if.sv
// jfps_if: valid/ready stream interfaces for samples in and results out.
// Depends on jfps_pkg.
`timescale 1ns / 1ps

interface jfps_sample_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [jfps_pkg::SAMPLE_BITS-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface jfps_result_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [jfps_pkg::SAMPLE_BITS-1:0]  average;
  logic [jfps_pkg::ROW_W-1:0]               out_row;
  logic [jfps_pkg::COL_W-1:0]               out_col;
  logic                                     last;

  modport source (output valid, output average, output out_row, output out_col,
                  output last, input ready);
  modport sink (input valid, input average, input out_row, input out_col,
                input last, output ready);
endinterface

FILE: design/jfps_front.sv
// jfps_front: config registers, raster counters, the two line stores and
// the first stage that forms pairwise neighbour sums. Depends on jfps_pkg.
`timescale 1ns / 1ps

module jfps_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [jfps_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [jfps_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [jfps_pkg::SAMPLE_BITS-1:0]      in_sample_i,
  output logic                                  push_o,
  output jfps_pkg::entry_t                      entry_o,
  input  logic                                  q_full_i
);

  localparam int SB = jfps_pkg::SAMPLE_BITS;
  localparam int CW = jfps_pkg::COL_W;
  localparam int WW = jfps_pkg::WID_W;
  localparam int RW = jfps_pkg::ROW_W;

  logic [WW-1:0] width_q;
  logic [RW-1:0] height_q;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic [SB-1:0] older_mem [jfps_pkg::MAX_WIDTH];
  logic [SB-1:0] newer_mem [jfps_pkg::MAX_WIDTH];
  logic [SB-1:0] ord_q, nrd_q, lft_q;

  logic          s1_vld_q;
  logic [SB-1:0] s1_bot_q, s1_left_q;
  logic [RW-1:0] s1_row_q;
  logic [CW-1:0] s1_col_q;
  logic          s1_last_q;

  logic          accept;
  logic          wr_width, wr_height;
  logic [WW-1:0] cfg_w, col_p1, col_p2;
  logic [RW:0]   row_p1;
  logic          wrap, has_res, is_last;
  logic [CW-1:0] nxt_col;

  assign wr_width  = cfg_we_i && (cfg_idx_i == jfps_pkg::REG_GRID_WIDTH);
  assign wr_height = cfg_we_i && (cfg_idx_i == jfps_pkg::REG_GRID_HEIGHT);

  // width saturates at the line store depth, zero behaves as one
  always_comb begin
    cfg_w = cfg_wdata_i[WW-1:0];
    if (cfg_w == '0) begin
      cfg_w = WW'(1);
    end else if (cfg_w > WW'(jfps_pkg::MAX_WIDTH)) begin
      cfg_w = WW'(jfps_pkg::MAX_WIDTH);
    end
  end

  assign in_ready_o = !s1_vld_q || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = s1_vld_q && !q_full_i;

  assign col_p1  = {1'b0, col_q} + WW'(1);
  assign col_p2  = {1'b0, col_q} + WW'(2);
  assign row_p1  = {1'b0, row_q} + (RW + 1)'(1);
  assign wrap    = col_p1 >= width_q;
  assign nxt_col = wrap ? '0 : col_p1[CW-1:0];
  assign has_res = (row_q >= RW'(2)) && (col_q != '0) && (col_p2 <= width_q);
  assign is_last = (row_p1 == {1'b0, height_q}) && (col_p2 == width_q);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (wr_width || wr_height) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      col_d = nxt_col;
      if (wrap) begin
        row_d = (row_p1 >= {1'b0, height_q}) ? '0 : row_p1[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= jfps_pkg::WIDTH_RST;
      height_q <= jfps_pkg::HEIGHT_RST;
      col_q    <= '0;
      row_q    <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      if (wr_width) begin
        width_q <= cfg_w;
      end
      if (wr_height) begin
        height_q <= (cfg_wdata_i == '0) ? RW'(1) : cfg_wdata_i[RW-1:0];
      end
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        s1_vld_q <= has_res;
      end else if (push_o) begin
        s1_vld_q <= 1'b0;
      end
    end
  end

  // line stores: top comes from the older row, right is read one column
  // ahead from the newer row; that read also feeds the shift into the
  // older row and the left neighbour on the following beats
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ord_q            <= older_mem[col_q];
      nrd_q            <= newer_mem[nxt_col];
      older_mem[col_q] <= nrd_q;
      newer_mem[col_q] <= in_sample_i;
      lft_q            <= nrd_q;
      s1_bot_q         <= in_sample_i;
      s1_left_q        <= lft_q;
      s1_row_q         <= row_q - RW'(1);
      s1_col_q         <= col_q;
      s1_last_q        <= is_last;
    end
  end

  always_comb begin
    entry_o.sum_tb = {ord_q[SB-1], ord_q} + {s1_bot_q[SB-1], s1_bot_q};
    entry_o.sum_lr = {s1_left_q[SB-1], s1_left_q} + {nrd_q[SB-1], nrd_q};
    entry_o.row    = s1_row_q;
    entry_o.col    = s1_col_q;
    entry_o.last   = s1_last_q;
  end

endmodule

FILE: design/jfps_queue.sv
// jfps_queue: short register queue between the front and back ends.
// Depends on jfps_pkg.
`timescale 1ns / 1ps

module jfps_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  jfps_pkg::entry_t  push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output jfps_pkg::entry_t  pop_data_o
);

  localparam int PW = jfps_pkg::QPTR_W;
  localparam int NW = jfps_pkg::QCNT_W;

  jfps_pkg::entry_t mem_q [jfps_pkg::QDEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [NW-1:0]    cnt_q;

  assign full_o     = cnt_q == NW'(jfps_pkg::QDEPTH);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(jfps_pkg::QDEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(jfps_pkg::QDEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: design/jfps_back.sv
// jfps_back: final four-way sum, floor divide by four and the output
// register. Depends on jfps_pkg.
`timescale 1ns / 1ps

module jfps_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  empty_i,
  input  jfps_pkg::entry_t                      entry_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [jfps_pkg::SAMPLE_BITS-1:0]      out_average_o,
  output logic [jfps_pkg::ROW_W-1:0]            out_row_o,
  output logic [jfps_pkg::COL_W-1:0]            out_col_o,
  output logic                                  out_last_o
);

  localparam int SB = jfps_pkg::SAMPLE_BITS;

  logic          vld_q;
  logic [SB+1:0] sum4;

  assign pop_o       = !empty_i && (!vld_q || out_ready_i);
  assign out_valid_o = vld_q;

  assign sum4 = {entry_i.sum_tb[SB], entry_i.sum_tb}
              + {entry_i.sum_lr[SB], entry_i.sum_lr};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
    end else if (out_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  // dropping the two low bits of the exact sum rounds toward minus infinity
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_average_o <= sum4[SB+1:2];
      out_row_o     <= entry_i.row;
      out_col_o     <= entry_i.col;
      out_last_o    <= entry_i.last;
    end
  end

endmodule

FILE: design/jacobi_five_point_stencil_unit.sv
// Five-point Jacobi stencil over a raster sample stream: one sample is taken
// per clock unless the queue is full and, once the lower neighbour of an
// interior point arrives, one result (floor of the mean of its four
// neighbours, with row, column and a last flag) leaves. The rate of one beat
// per cycle is set by the two line stores, each doing one read and one
// write per beat. Writing grid_width or grid_height restarts the grid.
// Depends on jfps_pkg, jfps_if, jfps_front, jfps_queue and jfps_back.
`timescale 1ns / 1ps

module jacobi_five_point_stencil_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [jfps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [jfps_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  jfps_sample_if.sink                        smp_i,
  jfps_result_if.source                      res_o
);

  logic             push, full, pop, empty;
  jfps_pkg::entry_t push_data, pop_data;
  logic [jfps_pkg::SAMPLE_BITS-1:0] avg;

  jfps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (smp_i.valid),
    .in_ready_o  (smp_i.ready),
    .in_sample_i (smp_i.sample),
    .push_o      (push),
    .entry_o     (push_data),
    .q_full_i    (full)
  );

  jfps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  jfps_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .entry_i       (pop_data),
    .pop_o         (pop),
    .out_valid_o   (res_o.valid),
    .out_ready_i   (res_o.ready),
    .out_average_o (avg),
    .out_row_o     (res_o.out_row),
    .out_col_o     (res_o.out_col),
    .out_last_o    (res_o.last)
  );

  assign res_o.average = avg;

endmodule

FILE: bench/tb_top.sv
// tb_top: self-checking bench for jacobi_five_point_stencil_unit, with random
// stalls on both streams and a scoreboard that predicts each interior point.
// Depends on jfps_pkg, jfps_if and the stencil unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int SAMPLE_BITS = jfps_pkg::SAMPLE_BITS;
  localparam int MAX_WIDTH   = jfps_pkg::MAX_WIDTH;
  localparam int WID_W       = jfps_pkg::WID_W;
  localparam int ROW_W       = jfps_pkg::ROW_W;
  localparam int COL_W       = jfps_pkg::COL_W;
  localparam int CFG_IDX_W   = jfps_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = jfps_pkg::CFG_DATA_W;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SMALL_ITEMS = 1050;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = 32'h8000_0000;
  // indexes past the register list, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  class stencil_scoreboard;
    typedef struct packed {
      logic [SAMPLE_BITS-1:0] average;
      logic [ROW_W-1:0]       row;
      logic [COL_W-1:0]       col;
      logic                   last;
    } point_t;

    // upper_line[c] holds row r-2 until shifted, lower_line[c] holds row r-1
    logic [SAMPLE_BITS-1:0] upper_line [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] lower_line [MAX_WIDTH];
    logic [WID_W-1:0]       width_reg;
    logic [ROW_W-1:0]       height_reg;
    int unsigned            col_at;
    int unsigned            row_at;
    point_t                 due_points[$];
    int unsigned            n_samples;
    int unsigned            n_points;
    int unsigned            n_grid_ends;
    int unsigned            n_errors;

    function new();
      width_reg  = jfps_pkg::WIDTH_RST;
      height_reg = jfps_pkg::HEIGHT_RST;
      col_at     = 0;
      row_at     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        jfps_pkg::REG_GRID_WIDTH:  width_reg = data[WID_W-1:0];
        jfps_pkg::REG_GRID_HEIGHT: height_reg = data[ROW_W-1:0];
        default: return;
      endcase
      col_at = 0;
      row_at = 0;
    endfunction

    function void take_sample(logic [SAMPLE_BITS-1:0] s);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      logic signed [SAMPLE_BITS+1:0] total;
      point_t p;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 : height_reg;
      c = col_at;
      r = row_at;
      n_samples++;
      if (r >= 2 && c >= 1 && c + 2 <= w) begin
        // exact sum, then floor by arithmetic shift
        total = $signed(upper_line[c]) + $signed(s) + $signed(upper_line[c-1])
              + $signed(lower_line[c+1]);
        p.average = total[SAMPLE_BITS+1:2];
        p.row     = ROW_W'(r - 1);
        p.col     = COL_W'(c);
        p.last    = (r + 1 == h) && (c + 2 == w);
        due_points.push_back(p);
      end
      upper_line[c] = lower_line[c];
      lower_line[c] = s;
      if (c + 1 >= w) begin
        col_at = 0;
        row_at = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_at = c + 1;
      end
    endfunction

    function void check_point(logic [SAMPLE_BITS-1:0] average, logic [ROW_W-1:0] row,
                              logic [COL_W-1:0] col, logic last);
      point_t p;
      if (due_points.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result avg %h row %0d col %0d last %b",
                 $time, average, row, col, last);
        return;
      end
      p = due_points.pop_front();
      n_points++;
      if (p.average !== average || p.row !== row || p.col !== col || p.last !== last) begin
        n_errors++;
        $display("%0t: expected avg %h row %0d col %0d last %b,", $time,
                 p.average, p.row, p.col, p.last);
        $display("%0t:      got avg %h row %0d col %0d last %b", $time,
                 average, row, col, last);
      end else if (last) begin
        n_grid_ends++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    calm;
  int unsigned           n_cycles;
  int unsigned           n_writes;

  stencil_scoreboard sb = new();

  jfps_sample_if smp_if ();
  jfps_result_if res_if ();

  jacobi_five_point_stencil_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .smp_i       (smp_if),
    .res_o       (res_if)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) res_if.ready <= calm || ($urandom_range(99) >= 20);
  end

  // both streams and the config port are sampled at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) sb.set_reg(cfg_idx, cfg_wdata);
      if (smp_if.valid && smp_if.ready) sb.take_sample(smp_if.sample);
      if (res_if.valid && res_if.ready)
        sb.check_point(res_if.average, res_if.out_row, res_if.out_col, res_if.last);
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points still due", n_cycles,
               sb.due_points.size());
      $display("jacobi_five_point_stencil_unit: mismatch");
      $finish;
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] draw_sample();
    logic [SAMPLE_BITS-1:0] u;
    u = $urandom;
    case ($urandom_range(7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return {{(SAMPLE_BITS-4){u[3]}}, u[3:0]};
      default: return u;
    endcase
  endfunction

  // valid is left high after a beat, so back-to-back beats show no gap
  task automatic send_sample(logic [SAMPLE_BITS-1:0] s);
    if (!calm) begin
      while ($urandom_range(99) < 20) begin
        smp_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= s;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
  endtask

  task automatic feed(int unsigned n);
    repeat (n) send_sample(draw_sample());
  endtask

  // wait until every due point has left, then let the pipe empty
  task automatic drain();
    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.due_points.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    n_writes++;
  endtask

  task automatic set_grid(logic [CFG_DATA_W-1:0] wd, logic [CFG_DATA_W-1:0] hd);
    if ($urandom_range(1)) begin
      cfg_write(jfps_pkg::REG_GRID_WIDTH, wd);
      cfg_write(jfps_pkg::REG_GRID_HEIGHT, hd);
    end else begin
      cfg_write(jfps_pkg::REG_GRID_HEIGHT, hd);
      cfg_write(jfps_pkg::REG_GRID_WIDTH, wd);
    end
  endtask

  initial begin
    int unsigned w;
    int unsigned n;
    int unsigned part;
    int unsigned small_items;
    int unsigned phase_no;
    logic [ROW_W-1:0] h;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    calm          = 1'b0;
    n_cycles      = 0;
    n_writes      = 0;
    smp_if.valid  = 1'b0;
    smp_if.sample = '0;
    res_if.ready  = 1'b0;
    small_items   = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: first row only, nothing may come out
    feed(6);

    // two 3x3 grids back to back; the neighbours of the centre hold one extreme,
    // everything else the other
    set_grid(16'd3, 16'd3);
    for (int k = 0; k < 9; k++) send_sample(k[0] ? SAMPLE_MAX : SAMPLE_MIN);
    for (int k = 0; k < 9; k++) send_sample(k[0] ? SAMPLE_MIN : SAMPLE_MAX);

    // oversized width with junk above bit 10 saturates to the full line;
    // part of the first row only, so nothing may come out
    set_grid(16'hFFFF, 16'd3);
    feed(40);

    phase_no = 0;
    while (small_items < SMALL_ITEMS) begin
      calm = (phase_no == 0) || ($urandom_range(5) == 0);
      if (phase_no == 0) begin
        // one whole grid with no idling on either side
        set_grid(16'd64, 16'd6);
        n = 64 * 6;
        feed(n);
        small_items += n;
      end else if ($urandom_range(9) == 0) begin
        // degenerate geometry: counters step, no interior points
        if ($urandom_range(1))
          set_grid(CFG_DATA_W'($urandom_range(0, 2)), CFG_DATA_W'($urandom_range(3, 8)));
        else
          set_grid(CFG_DATA_W'($urandom_range(3, 12)), CFG_DATA_W'($urandom_range(0, 2)));
        feed($urandom_range(4, 30));
      end else begin
        w = ($urandom_range(3) == 0) ? $urandom_range(13, 64) : $urandom_range(3, 12);
        h = ($urandom_range(7) == 0) ? 16'hFFFF : ROW_W'($urandom_range(3, 6));
        set_grid({5'($urandom), 11'(w)}, h);
        if (h == 16'hFFFF) n = w * $urandom_range(3, 6);
        else n = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
        if ($urandom_range(3) == 0) begin
          // spare index write mid-grid must not restart the grid
          part = $urandom_range(1, n - 1);
          feed(part);
          cfg_write($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom));
          feed(n - part);
        end else begin
          feed(n);
        end
        small_items += n;
      end
      phase_no++;
    end

    drain();
    $display("covered %0d samples over %0d geometry phases with %0d register writes",
             sb.n_samples, phase_no + 3, n_writes);
    $display("checked %0d interior points, %0d grid ends flagged", sb.n_points,
             sb.n_grid_ends);
    if (sb.n_errors == 0 && sb.due_points.size() == 0)
      $display("jacobi_five_point_stencil_unit: match");
    else
      $display("jacobi_five_point_stencil_unit: mismatch");
    $finish;
  end

endmodule
